// ----- hdl/bole_pkg.sv -----
// Shared types and constants for the bounded ordered list engine.
// No dependencies; used by bole_cell and bounded_ordered_list_engine.
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int OP_W         = 4;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 8;
	localparam int LEN_W        = 7;
	localparam int STAT_W       = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INS_HEAD = 4'd0,
		OP_INS_TAIL = 4'd1,
		OP_INS_AT   = 4'd2,
		OP_DEL_HEAD = 4'd3,
		OP_DEL_TAIL = 4'd4,
		OP_DEL_AT   = 4'd5,
		OP_SEARCH   = 4'd6,
		OP_LENGTH   = 4'd7,
		OP_CLEAR    = 4'd8,
		OP_DUMP     = 4'd9
	} op_e;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_e;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INS,
		CMD_DEL,
		CMD_ROT,
		CMD_CMP
	} cell_cmd_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DUMP
	} state_e;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic                     found;
		logic [LEN_W-1:0]         length;
		logic signed [DATA_W-1:0] element;
		logic                     last;
	} rsp_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		cell_cmd_e                cmd;
		logic [POS_W-1:0]         idx;
		logic [POS_W-1:0]         tail_idx;
		logic signed [DATA_W-1:0] value;
		logic [LEN_W-1:0]         count;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/bole_cell.sv -----
// One list slot: holds an entry, shifts to/from neighbors, compares for search.
// Depends on bole_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bole_cell #(
	parameter int INDEX = 0
) (
	input  wire                                    clk,
	input  wire bole_pkg::cell_ctrl_t              ctrl,
	input  wire logic signed [bole_pkg::DATA_W-1:0] left,
	input  wire logic signed [bole_pkg::DATA_W-1:0] right,
	input  wire logic signed [bole_pkg::DATA_W-1:0] head,
	output logic signed [bole_pkg::DATA_W-1:0]      entry,
	output logic                                   match
);

	localparam logic [bole_pkg::POS_W-1:0] MY_IDX = bole_pkg::POS_W'(INDEX);

	logic signed [bole_pkg::DATA_W-1:0] entry_q;
	logic                               match_q;
	logic [bole_pkg::POS_W-1:0]         count_ext;

	assign count_ext = {1'b0, ctrl.count};

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			bole_pkg::CMD_INS: begin
				if (MY_IDX > ctrl.idx) begin
					entry_q <= left;
				end else if (MY_IDX == ctrl.idx) begin
					entry_q <= ctrl.value;
				end
			end
			bole_pkg::CMD_DEL: begin
				if (MY_IDX >= ctrl.idx) begin
					entry_q <= right;
				end
			end
			// rotate the occupied part left by one; head wraps to the tail
			bole_pkg::CMD_ROT: begin
				if (MY_IDX < ctrl.tail_idx) begin
					entry_q <= right;
				end else if (MY_IDX == ctrl.tail_idx) begin
					entry_q <= head;
				end
			end
			bole_pkg::CMD_CMP: begin
				match_q <= (entry_q == ctrl.value) && (MY_IDX < count_ext);
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

`default_nettype wire

// ----- hdl/bounded_ordered_list_engine.sv -----
// Bounded ordered list engine: row of bole_cell slots plus the sequencer.
// Request and ST_EXEC are registered first, then result and strobe.
// Requests are taken only while idle; busy covers ST_EXEC and, for a dump, ST_DUMP.
// Dump: busy through ST_DUMP, one element strobed per cycle from the head cell.
// The receiver cannot stall: every result shows for exactly one cycle.
// Reset clears the element count and the sequencer; entries stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list_engine #(
	parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire bole_pkg::req_t  request,
	output logic                 strobe,
	output bole_pkg::rsp_t       result
);

	localparam logic [bole_pkg::LEN_W-1:0] CAP_L = bole_pkg::LEN_W'(CAPACITY);

	bole_pkg::state_e                   state_q, state_d;
	bole_pkg::req_t                     req_q;
	bole_pkg::rsp_t                     rsp_q, rsp_d;
	bole_pkg::cell_ctrl_t               ctrl;
	logic [bole_pkg::LEN_W-1:0]         count_q, count_d;
	logic [bole_pkg::LEN_W-1:0]         rem_q, rem_d;
	logic                               strobe_q, strobe_d;
	logic [bole_pkg::POS_W-1:0]         cnt_ext;
	logic signed [bole_pkg::DATA_W-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0]                match_w;

	assign cnt_ext = {1'b0, count_q};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [bole_pkg::DATA_W-1:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end
		// last slot just keeps its entry on a delete shift
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = entry_w[i];
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end
		bole_cell #(.INDEX(i)) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.left  (left_w),
			.right (right_w),
			.head  (entry_w[0]),
			.entry (entry_w[i]),
			.match (match_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bole_pkg::ST_IDLE;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= request;
		end
		rem_q <= rem_d;
		rsp_q <= rsp_d;
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		rem_d         = rem_q;
		strobe_d      = 1'b0;
		rsp_d         = rsp_q;
		busy          = (state_q != bole_pkg::ST_IDLE);
		ctrl.cmd      = bole_pkg::CMD_HOLD;
		ctrl.idx      = '0;
		ctrl.tail_idx = cnt_ext - 1'b1;
		ctrl.value    = req_q.value;
		ctrl.count    = count_q;

		unique case (state_q)
			bole_pkg::ST_IDLE: begin
				if (start) begin
					state_d = bole_pkg::ST_EXEC;
				end
			end
			bole_pkg::ST_EXEC: begin
				state_d       = bole_pkg::ST_IDLE;
				strobe_d      = 1'b1;
				rsp_d.status  = bole_pkg::STAT_OK;
				rsp_d.found   = 1'b0;
				rsp_d.element = '0;
				rsp_d.last    = 1'b1;
				unique case (req_q.op) inside
					bole_pkg::OP_INS_HEAD, bole_pkg::OP_INS_TAIL, bole_pkg::OP_INS_AT: begin
						if (count_q >= CAP_L) begin
							rsp_d.status = bole_pkg::STAT_FULL;
						end else if (req_q.op == bole_pkg::OP_INS_HEAD) begin
							ctrl.cmd = bole_pkg::CMD_INS;
							ctrl.idx = '0;
							count_d  = count_q + 1'b1;
						end else if (req_q.op == bole_pkg::OP_INS_TAIL) begin
							ctrl.cmd = bole_pkg::CMD_INS;
							ctrl.idx = cnt_ext;
							count_d  = count_q + 1'b1;
						end else if (req_q.position != '0 &&
						             req_q.position <= cnt_ext + 1'b1) begin
							ctrl.cmd = bole_pkg::CMD_INS;
							ctrl.idx = req_q.position - 1'b1;
							count_d  = count_q + 1'b1;
						end else begin
							rsp_d.status = bole_pkg::STAT_RANGE;
						end
					end
					bole_pkg::OP_DEL_HEAD, bole_pkg::OP_DEL_TAIL, bole_pkg::OP_DEL_AT: begin
						if (count_q == '0) begin
							rsp_d.status = bole_pkg::STAT_EMPTY;
						end else if (req_q.op == bole_pkg::OP_DEL_HEAD) begin
							ctrl.cmd = bole_pkg::CMD_DEL;
							ctrl.idx = '0;
							count_d  = count_q - 1'b1;
						end else if (req_q.op == bole_pkg::OP_DEL_TAIL) begin
							ctrl.cmd = bole_pkg::CMD_DEL;
							ctrl.idx = cnt_ext - 1'b1;
							count_d  = count_q - 1'b1;
						end else if (req_q.position != '0 && req_q.position <= cnt_ext) begin
							ctrl.cmd = bole_pkg::CMD_DEL;
							ctrl.idx = req_q.position - 1'b1;
							count_d  = count_q - 1'b1;
						end else begin
							rsp_d.status = bole_pkg::STAT_RANGE;
						end
					end
					bole_pkg::OP_SEARCH: begin
						// cells register their match bits; OR taken at the output
						ctrl.cmd    = bole_pkg::CMD_CMP;
						rsp_d.found = 1'b1;
					end
					bole_pkg::OP_LENGTH: begin
					end
					bole_pkg::OP_CLEAR: begin
						count_d = '0;
					end
					bole_pkg::OP_DUMP: begin
						if (count_q == '0) begin
							rsp_d.status = bole_pkg::STAT_EMPTY;
						end else begin
							ctrl.cmd      = bole_pkg::CMD_ROT;
							rsp_d.element = entry_w[0];
							rsp_d.last    = (count_q == 7'd1);
							if (count_q != 7'd1) begin
								state_d = bole_pkg::ST_DUMP;
								rem_d   = count_q - 1'b1;
							end
						end
					end
					default: begin
						rsp_d.status = bole_pkg::STAT_RANGE;
					end
				endcase
				rsp_d.length = count_d;
			end
			bole_pkg::ST_DUMP: begin
				// after count rotations the list is back in order
				strobe_d      = 1'b1;
				ctrl.cmd      = bole_pkg::CMD_ROT;
				rsp_d.status  = bole_pkg::STAT_OK;
				rsp_d.found   = 1'b0;
				rsp_d.length  = count_q;
				rsp_d.element = entry_w[0];
				rsp_d.last    = (rem_q == 7'd1);
				rem_d         = rem_q - 1'b1;
				if (rem_q == 7'd1) begin
					state_d = bole_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bole_pkg::ST_IDLE;
			end
		endcase
	end

	assign strobe = strobe_q;

	always_comb begin
		result       = rsp_q;
		result.found = rsp_q.found & (|match_w);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_L)
		else $error("element count above capacity");

	a_exec_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bole_pkg::ST_EXEC |=> strobe)
		else $error("execute cycle produced no result");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("busy after final result");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("idle with dump results still pending");

endmodule

`default_nettype wire

// ----- tb/sv/tb_bounded_ordered_list_engine.sv -----
// Self-checking testbench for bounded_ordered_list_engine: directed table, fill-to-full checks, then random traffic.
// Uses a queue-based list predictor, or the directed table's expected values, to check every strobed result.
// Depends on bole_pkg and bounded_ordered_list_engine.
`timescale 1ns / 1ps

module tb_bounded_ordered_list_engine;
	import bole_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int RAND_ITEMS = 175;
	localparam int CALM_TAIL = 40;    // final items sent back to back
	localparam int STALL_LIMIT = 2000;
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd10;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;
	localparam logic signed [DATA_W-1:0] V_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] V_MAX = 32'sh7fff_ffff;

	typedef struct {
		req_t rq;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  request;
	logic  strobe;
	rsp_t  result;

	logic signed [DATA_W-1:0] list_vals[$];  // predicted list contents, head first
	rsp_t                     step_rsp[$];   // results of the latest predicted request
	rsp_t                     rsp_due[$];    // results still to arrive, oldest first
	dir_row_t                 dir_rows[$];
	rsp_t                     want_rsp;
	int                       mismatches = 0;
	int                       stall_cycles = 0;

	bounded_ordered_list_engine #(.CAPACITY(CAP)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.strobe  (strobe),
		.result  (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// list behavior: fills step_rsp and updates list_vals
	function automatic void list_apply(input req_t r);
		rsp_t res;
		int   n;
		n = list_vals.size();
		step_rsp.delete();
		res = '0;
		res.status = STAT_OK;
		res.last = 1'b1;
		case (r.op)
			OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
				if (n >= CAP)
					res.status = STAT_FULL;
				else if (r.op == OP_INS_HEAD)
					list_vals.push_front(r.value);
				else if (r.op == OP_INS_TAIL)
					list_vals.push_back(r.value);
				else if (r.position >= 1 && r.position <= n + 1)
					list_vals.insert(int'(r.position) - 1, r.value);
				else
					res.status = STAT_RANGE;
			end
			OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_AT: begin
				if (n == 0)
					res.status = STAT_EMPTY;
				else if (r.op == OP_DEL_HEAD)
					list_vals.delete(0);
				else if (r.op == OP_DEL_TAIL)
					list_vals.delete(n - 1);
				else if (r.position >= 1 && r.position <= n)
					list_vals.delete(int'(r.position) - 1);
				else
					res.status = STAT_RANGE;
			end
			OP_SEARCH: begin
				foreach (list_vals[i])
					if (list_vals[i] == r.value)
						res.found = 1'b1;
			end
			OP_LENGTH: ;
			OP_CLEAR: list_vals.delete();
			OP_DUMP: begin
				if (n == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					for (int i = 0; i < n; i++) begin
						res.length = LEN_W'(n);
						res.element = list_vals[i];
						res.last = (i == n - 1);
						step_rsp.push_back(res);
					end
					return;
				end
			end
			default: res.status = STAT_RANGE;
		endcase
		res.length = LEN_W'(list_vals.size());
		step_rsp.push_back(res);
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
			input logic [POS_W-1:0] position, input bit typed = 1'b0,
			input status_e status = STAT_OK, input logic found = 1'b0,
			input logic [LEN_W-1:0] length = '0);
		dir_row_t row;
		row.rq.op = op;
		row.rq.value = value;
		row.rq.position = position;
		row.typed = typed;
		row.want = '0;
		row.want.status = status;
		row.want.found = found;
		row.want.length = length;
		row.want.last = 1'b1;
		dir_rows.push_back(row);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return V_MIN;
			1: return V_MAX;
			2, 3, 4, 5: return $signed($urandom_range(0, 7)) - 4;  // small, so values repeat
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t gen_item(input bit filling);
		req_t r;
		int   n;
		int   d;
		int   ins_w;
		int   del_w;
		n = list_vals.size();
		ins_w = filling ? 60 : 20;
		del_w = filling ? 15 : 55;
		r.value = pick_value();
		r.position = POS_W'($urandom_range(0, 255));
		d = $urandom_range(0, 99);
		if (d < 3) begin
			r.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end else if (d < 3 + ins_w) begin
			r.op = OP_W'($urandom_range(OP_INS_HEAD, OP_INS_AT));
			if (r.op == OP_INS_AT && $urandom_range(0, 99) < 85)
				r.position = POS_W'($urandom_range(1, n + 1));
		end else if (d < 3 + ins_w + del_w) begin
			r.op = OP_W'($urandom_range(OP_DEL_HEAD, OP_DEL_AT));
			if (r.op == OP_DEL_AT && $urandom_range(0, 99) < 85)
				r.position = POS_W'($urandom_range(1, (n > 0) ? n : 1));
		end else begin
			d = $urandom_range(0, 21);
			if (d < 11) begin
				r.op = OP_SEARCH;
				if (n > 0 && $urandom_range(0, 1))
					r.value = list_vals[$urandom_range(0, n - 1)];
			end else if (d < 16) begin
				r.op = OP_LENGTH;
			end else if (d < 21) begin
				r.op = OP_DUMP;
			end else begin
				r.op = OP_CLEAR;
			end
		end
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send(input req_t r, input bit typed = 1'b0, input rsp_t want = '0);
		start = 1'b1;
		request = r;
		do
			@(posedge clk);
		while (busy);
		list_apply(r);
		if (typed)
			rsp_due.push_back(want);
		else
			foreach (step_rsp[i])
				rsp_due.push_back(step_rsp[i]);
		@(negedge clk);
	endtask

	task automatic idle_gap(input int cycles);
		start = 1'b0;
		repeat (cycles) begin
			request.op = OP_W'($urandom);
			request.value = $urandom;
			request.position = POS_W'($urandom);
			@(negedge clk);
		end
	endtask

	task automatic wait_drain();
		start = 1'b0;
		while (rsp_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_v,
			input logic [DATA_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (rsp_due.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %p", $time, result);
				mismatches++;
			end else begin
				want_rsp = rsp_due.pop_front();
				check_field("status", DATA_W'(want_rsp.status), DATA_W'(result.status));
				check_field("found", DATA_W'(want_rsp.found), DATA_W'(result.found));
				check_field("length", DATA_W'(want_rsp.length), DATA_W'(result.length));
				check_field("element", want_rsp.element, result.element);
				check_field("last", DATA_W'(want_rsp.last), DATA_W'(result.last));
			end
		end
	end

	// watchdog: no request or result accepted for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		bit     filling;
		int     idle_pct;
		req_t   r;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty-list cases, position bounds, extremes, unused opcodes
		add_row(OP_LENGTH, 0, 0, 1, STAT_OK, 0, 0);
		add_row(OP_DUMP, 0, 0, 1, STAT_EMPTY, 0, 0);
		add_row(OP_DEL_HEAD, 0, 0, 1, STAT_EMPTY, 0, 0);
		add_row(OP_DEL_TAIL, 0, 0, 1, STAT_EMPTY, 0, 0);
		add_row(OP_DEL_AT, 0, 0, 1, STAT_EMPTY, 0, 0);
		add_row(OP_SEARCH, 0, 0, 1, STAT_OK, 0, 0);
		add_row(OP_INS_AT, 5, 0, 1, STAT_RANGE, 0, 0);
		add_row(OP_INS_AT, 5, 2, 1, STAT_RANGE, 0, 0);
		add_row(OP_INS_AT, V_MIN, 1, 1, STAT_OK, 0, 1);
		add_row(OP_INS_HEAD, V_MAX, 0, 1, STAT_OK, 0, 2);
		add_row(OP_INS_TAIL, -1, 255, 1, STAT_OK, 0, 3);
		add_row(OP_SEARCH, V_MIN, 0);
		add_row(OP_SEARCH, 0, 0);
		add_row(OP_DEL_AT, 0, 4, 1, STAT_RANGE, 0, 3);
		add_row(OP_DEL_AT, 0, 255, 1, STAT_RANGE, 0, 3);
		add_row(OP_INS_AT, 0, 4, 1, STAT_OK, 0, 4);
		add_row(OP_DUMP, 0, 0);
		add_row(OP_UNUSED_LO, 0, 0, 1, STAT_RANGE, 0, 4);
		add_row(OP_UNUSED_HI, -1, 255, 1, STAT_RANGE, 0, 4);
		add_row(OP_DEL_AT, 0, 2);
		add_row(OP_DEL_HEAD, 0, 0);
		add_row(OP_DEL_TAIL, 0, 0);
		add_row(OP_DUMP, 0, 0);
		add_row(OP_CLEAR, 0, 0, 1, STAT_OK, 0, 0);
		add_row(OP_SEARCH, -1, 0, 1, STAT_OK, 0, 0);
		foreach (dir_rows[i])
			send(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
		wait_drain();

		// fill up, then hit the full list: full takes priority over a bad position
		while (list_vals.size() < CAP) begin
			r.op = OP_INS_TAIL;
			r.value = pick_value();
			r.position = POS_W'($urandom);
			send(r);
		end
		r.value = pick_value();
		r.op = OP_INS_AT;
		r.position = 0;
		send(r);
		r.op = OP_INS_HEAD;
		send(r);
		r.op = OP_INS_TAIL;
		send(r);
		r.op = OP_DEL_AT;
		r.position = 8'd255;
		send(r);
		r.op = OP_DUMP;
		send(r);

		filling = 1'b0;
		idle_pct = 0;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 30 == 0)
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 25;
					default: idle_pct = 60;
				endcase
			if (i >= RAND_ITEMS - CALM_TAIL)
				idle_pct = 0;
			if (list_vals.size() >= CAP)
				filling = 1'b0;
			else if (list_vals.size() == 0 || $urandom_range(0, 99) < 4)
				filling = (list_vals.size() == 0) ? 1'b1 : ~filling;
			if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
				idle_gap($urandom_range(1, 17));
			if (idle_pct != 0 && $urandom_range(0, 99) < 3)
				wait_drain();
			send(gen_item(filling));
		end

		wait_drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
